// ----- src/stack_allocator_engine_assert.svh -----
// Assertion macros for the stack allocator engine.
// Define NO_ASSERTIONS to compile them out; clock is aclk, reset is aresetn.
`ifndef STACK_ALLOCATOR_ENGINE_ASSERT_SVH
`define STACK_ALLOCATOR_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Expression holds at every clock edge out of reset.
`define SAE_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("stack allocator assertion failed");

// Antecedent implies consequent in the same cycle.
`define SAE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("stack allocator assertion failed");

// Antecedent implies consequent in the next cycle.
`define SAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stack allocator assertion failed");

`else

`define SAE_ASSERT_ALWAYS(label, expr)
`define SAE_ASSERT_SAME(label, ante, cons)
`define SAE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/sae_pkg.sv -----
// Package for the stack allocator engine: widths, limits, status and register codes.
// No dependencies.
`timescale 1ns / 1ps

package sae_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int TAG_BYTES  = 8;

    localparam int ADDR_W = 32;
    localparam int TOP_W  = 21;
    localparam int REQ_W  = 21;
    localparam int TAG_W  = 21;
    localparam int LG_W   = 4;
    localparam int PAD_W  = (1 << LG_W) - 1;
    localparam int NEED_W = TOP_W + 2;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PTR_W  = $clog2(MAX_BLOCKS);
    localparam int STAT_W = 3;
    localparam int IDX_W  = 1;

    localparam logic [TOP_W-1:0] REGION_RESET = TOP_W'(1048576);

    localparam logic [0:0] OP_ALLOC = 1'b0;
    localparam logic [0:0] OP_FREE  = 1'b1;

    localparam logic [IDX_W-1:0] REG_BASE_ADDRESS = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_REGION_SIZE  = IDX_W'(1);

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_ZERO_SIZE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

endpackage

// ----- src/stack_allocator_engine.sv -----
// Stack allocator engine: LIFO region allocator with aligned allocation.
// Depends on sae_pkg and stack_allocator_engine_assert.svh.
`timescale 1ns / 1ps

// One request per clock unless stalled. A word is accepted whenever the result
// register is empty or being drained, and its status and address appear in the
// result register on the next cycle; the top offset, block count and cached top
// tags are updated at the same edge, so back-to-back allocates and frees run at
// one word per cycle. Tags live in a 64-entry memory; the top two tags are held
// in registers and the one below is fetched by a registered read on each pop,
// which keeps consecutive frees at full rate. No clearing pass after reset.
// Configuration writes take effect at once and are meant for idle periods.
module stack_allocator_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sae_pkg::IDX_W-1:0]     cfg_index,
    input  logic [sae_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [sae_pkg::REQ_W-1:0]     s_request_bytes,
    input  logic [sae_pkg::LG_W-1:0]      s_align_log2,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sae_pkg::ADDR_W-1:0]    m_block_address,
    output logic [sae_pkg::STAT_W-1:0]    m_status
);
    import sae_pkg::*;

    logic [ADDR_W-1:0] base_address_reg;
    logic [TOP_W-1:0]  region_size_reg;
    logic [TOP_W-1:0]  top_offset_reg, top_offset_next;
    logic [CNT_W-1:0]  block_count_reg, block_count_next;
    logic [TAG_W-1:0]  top_tag_reg;
    logic [TAG_W-1:0]  second_tag_reg;
    logic [TAG_W-1:0]  tag_mem [MAX_BLOCKS];

    logic              m_valid_reg;
    logic [ADDR_W-1:0] m_block_address_reg, m_block_address_next;
    status_t           m_status_reg, m_status_next;

    logic              accept;
    logic              do_push, do_pop;
    logic [ADDR_W-1:0] cur_addr;
    logic [PAD_W:0]    align_one;
    logic [PAD_W-1:0]  align_mask;
    logic [PAD_W-1:0]  neg_low;
    logic [PAD_W-1:0]  pad;
    logic [NEED_W-1:0] need;
    logic              fits;
    logic [TAG_W-1:0]  push_tag;
    logic [TAG_W:0]    back;
    logic [PTR_W-1:0]  fetch_ptr;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // Pad the current top up to the alignment.
    assign cur_addr   = base_address_reg + ADDR_W'(top_offset_reg);
    assign align_one  = (PAD_W + 1)'(1) << s_align_log2;
    assign align_mask = PAD_W'(align_one - (PAD_W + 1)'(1));
    assign neg_low    = ~cur_addr[PAD_W-1:0] + PAD_W'(1);
    assign pad        = neg_low & align_mask;
    assign need       = NEED_W'(top_offset_reg) + NEED_W'(pad)
                      + NEED_W'(s_request_bytes) + NEED_W'(TAG_BYTES);
    assign fits       = need <= NEED_W'(region_size_reg);
    assign push_tag   = TAG_W'(pad) + s_request_bytes;
    assign back       = (TAG_W + 1)'(top_tag_reg) + (TAG_W + 1)'(TAG_BYTES);
    // Entry two below the current top becomes the second tag after a pop.
    assign fetch_ptr  = PTR_W'(block_count_reg - CNT_W'(3));

    always_comb begin
        do_push              = 1'b0;
        do_pop               = 1'b0;
        m_status_next        = ST_OK;
        m_block_address_next = '0;
        top_offset_next      = top_offset_reg;
        block_count_next     = block_count_reg;
        if (s_op == OP_ALLOC) begin
            if (s_request_bytes == '0) begin
                m_status_next = ST_ZERO_SIZE;
            end else if (block_count_reg >= CNT_W'(MAX_BLOCKS)) begin
                m_status_next = ST_FULL;
            end else if (!fits) begin
                m_status_next = ST_NO_SPACE;
            end else begin
                do_push              = accept;
                m_block_address_next = cur_addr + ADDR_W'(pad);
                top_offset_next      = need[TOP_W-1:0];
                block_count_next     = block_count_reg + CNT_W'(1);
            end
        end else begin
            if (block_count_reg == '0) begin
                m_status_next = ST_EMPTY;
            end else begin
                do_pop           = accept;
                block_count_next = block_count_reg - CNT_W'(1);
                if (back > (TAG_W + 1)'(top_offset_reg)) begin
                    top_offset_next = '0;
                end else begin
                    top_offset_next = top_offset_reg - TOP_W'(back);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_address_reg <= '0;
            region_size_reg  <= REGION_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BASE_ADDRESS: base_address_reg <= cfg_wdata;
                REG_REGION_SIZE:  region_size_reg  <= cfg_wdata[TOP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_offset_reg  <= '0;
            block_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                top_offset_reg  <= top_offset_next;
                block_count_reg <= block_count_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_block_address_reg <= m_block_address_next;
            m_status_reg        <= m_status_next;
        end
    end

    // Tag memory holds every live tag; the top two are cached.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            tag_mem[block_count_reg[PTR_W-1:0]] <= push_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            top_tag_reg    <= push_tag;
            second_tag_reg <= top_tag_reg;
        end else if (do_pop) begin
            top_tag_reg    <= second_tag_reg;
            second_tag_reg <= tag_mem[fetch_ptr];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_block_address = m_block_address_reg;
    assign m_status        = m_status_reg;

`include "stack_allocator_engine_assert.svh"

    `SAE_ASSERT_ALWAYS(a_count_bound, block_count_reg <= CNT_W'(MAX_BLOCKS))
    `SAE_ASSERT_SAME(a_empty_top_zero, block_count_reg == '0, top_offset_reg == '0)
    `SAE_ASSERT_SAME(a_addr_only_on_ok, m_valid_reg && m_status_reg != ST_OK, m_block_address_reg == '0)
    `SAE_ASSERT_NEXT(a_push_counts, do_push, block_count_reg == $past(block_count_reg) + CNT_W'(1))
    `SAE_ASSERT_NEXT(a_pop_counts, do_pop, block_count_reg == $past(block_count_reg) - CNT_W'(1))

endmodule

// ----- verif/stack_allocator_engine_tb.sv -----
// Testbench for stack_allocator_engine: directed and random allocate/free words
// checked against a scoreboard that tracks the top offset, tags and registers.
// Depends on sae_pkg and the stack_allocator_engine RTL.
`timescale 1ns / 1ps

module stack_allocator_engine_tb;

    import sae_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] block_address;
        status_t           status;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [ADDR_W-1:0] base_address;
        logic [TOP_W-1:0]  region_size;
        logic [TOP_W-1:0]  top_offset;
        logic [TAG_W-1:0]  tag_stack [MAX_BLOCKS];
        int unsigned       block_count;
        alloc_result_t     pending_results [$];
        int                errors;

        function new();
            base_address = '0;
            region_size  = REGION_RESET;
            top_offset   = '0;
            block_count  = 0;
            errors       = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] index, logic [ADDR_W-1:0] data);
            case (index)
                REG_BASE_ADDRESS: base_address = data;
                REG_REGION_SIZE:  region_size  = data[TOP_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted word and update the allocator state.
        function void note_request(logic op, logic [REQ_W-1:0] req, logic [LG_W-1:0] lg);
            alloc_result_t     r;
            logic [ADDR_W-1:0] addr;
            logic [ADDR_W-1:0] mask;
            logic [ADDR_W-1:0] pad;
            logic [TOP_W+1:0]  need;
            logic [TOP_W+1:0]  back;
            r.block_address = '0;
            r.status        = ST_OK;
            if (op == OP_FREE) begin
                if (block_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    block_count--;
                    back = (TOP_W+2)'(tag_stack[block_count]) + (TOP_W+2)'(TAG_BYTES);
                    if (back > (TOP_W+2)'(top_offset))
                        top_offset = '0;
                    else
                        top_offset = top_offset - back[TOP_W-1:0];
                end
            end else if (req == '0) begin
                r.status = ST_ZERO_SIZE;
            end else if (block_count >= MAX_BLOCKS) begin
                r.status = ST_FULL;
            end else begin
                addr = base_address + ADDR_W'(top_offset);
                mask = (ADDR_W'(1) << lg) - ADDR_W'(1);
                pad  = (-addr) & mask;
                need = (TOP_W+2)'(top_offset) + (TOP_W+2)'(pad) + (TOP_W+2)'(req)
                     + (TOP_W+2)'(TAG_BYTES);
                if (need > (TOP_W+2)'(region_size)) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    tag_stack[block_count] = TAG_W'(pad + ADDR_W'(req));
                    block_count++;
                    top_offset = need[TOP_W-1:0];
                    r.block_address = addr + pad;
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [ADDR_W-1:0] block_address,
                                   logic [STAT_W-1:0] status);
            alloc_result_t r;
            if (pending_results.size() == 0) begin
                $error("unexpected word: block_address %h status %0d", block_address, status);
                errors++;
            end else begin
                r = pending_results.pop_front();
                if (block_address !== r.block_address) begin
                    $error("block_address: expected %h, got %h", r.block_address, block_address);
                    errors++;
                end
                if (status !== r.status) begin
                    $error("status: expected %0d, got %0d", r.status, status);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_index;
    logic [ADDR_W-1:0]   cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic                s_op;
    logic [REQ_W-1:0]    s_request_bytes;
    logic [LG_W-1:0]     s_align_log2;
    logic                m_valid;
    logic                m_ready;
    logic [ADDR_W-1:0]   m_block_address;
    logic [STAT_W-1:0]   m_status;

    alloc_scoreboard book;
    bit              idle_on;

    stack_allocator_engine i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_request_bytes (s_request_bytes),
        .s_align_log2    (s_align_log2),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_block_address (m_block_address),
        .m_status        (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("stack_allocator_engine_tb NOT OK");
        $finish;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int c;
        c = $urandom_range(0, 99);
        if (!idle_on || c < 60)
            return 0;
        if (c < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            book.note_request(s_op, s_request_bytes, s_align_log2);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_result(m_block_address, m_status);
    end

    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            m_ready <= 1'b1;
            if (!idle_on) begin
                @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    // Present one word and hold it until accepted; valid stays high for the next one.
    task automatic send_word(input logic op, input logic [REQ_W-1:0] req,
                             input logic [LG_W-1:0] lg);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_request_bytes <= req;
        s_align_log2    <= lg;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (book.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [TOP_W-1:0] region);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BASE_ADDRESS;
        cfg_wdata <= base;
        @(posedge aclk);
        book.write_reg(REG_BASE_ADDRESS, base);
        cfg_index <= REG_REGION_SIZE;
        cfg_wdata <= ADDR_W'(region);
        @(posedge aclk);
        book.write_reg(REG_REGION_SIZE, ADDR_W'(region));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_word(input int alloc_pct, input int max_req);
        int c;
        c = $urandom_range(0, 99);
        if (c >= alloc_pct) begin
            send_word(OP_FREE, REQ_W'($urandom), LG_W'($urandom));
        end else begin
            c = $urandom_range(0, 99);
            if (c < 80)
                send_word(OP_ALLOC, REQ_W'($urandom_range(1, max_req)),
                          LG_W'($urandom_range(0, 12)));
            else if (c < 88)
                send_word(OP_ALLOC, REQ_W'($urandom), LG_W'($urandom));
            else if (c < 94)
                send_word(OP_ALLOC, '0, LG_W'($urandom));
            else
                send_word(OP_ALLOC, REQ_W'($urandom_range(1, 64)),
                          LG_W'($urandom_range(13, 15)));
        end
    endtask

    initial begin
        int ph;
        int k;
        int alloc_pct;
        int max_req;
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= REG_BASE_ADDRESS;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_op            <= OP_ALLOC;
        s_request_bytes <= '0;
        s_align_log2    <= '0;
        idle_on = 1'b1;
        book = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset registers: empty free, zero size, alignments, oversize requests.
        send_word(OP_FREE, '0, '0);
        send_word(OP_ALLOC, '0, '0);
        send_word(OP_ALLOC, 21'd1, 4'd0);
        send_word(OP_ALLOC, 21'd1, 4'd12);
        send_word(OP_ALLOC, 21'd1, 4'd15);
        send_word(OP_ALLOC, 21'h1F_FFFF, 4'd15);
        send_word(OP_ALLOC, 21'd1048576, 4'd0);
        send_word(OP_FREE, 21'h1F_FFFF, 4'd15);
        send_word(OP_FREE, '0, '0);
        send_word(OP_FREE, '0, '0);
        send_word(OP_FREE, '0, '0);
        drain_results();

        // Exact fit at the top of the address space, then padding that wraps to zero.
        configure(32'hFFFF_FFF8, 21'd24);
        send_word(OP_ALLOC, 21'd16, 4'd0);
        send_word(OP_ALLOC, 21'd1, 4'd0);
        send_word(OP_FREE, '0, '0);
        send_word(OP_ALLOC, 21'd8, 4'd4);
        send_word(OP_FREE, '0, '0);
        drain_results();

        // Empty region.
        configure(32'h0, 21'd0);
        send_word(OP_ALLOC, 21'd1, 4'd0);
        send_word(OP_ALLOC, '0, 4'd3);
        send_word(OP_FREE, '0, '0);

        for (ph = 0; ph < 10; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    configure(32'h0, 21'd1048576);
                    alloc_pct = 60; max_req = 4096; idle_on = 1'b1;
                end
                1: begin
                    // fill the tag store
                    configure(32'hFFFF_FFFF, 21'h1F_FFFF);
                    alloc_pct = 90; max_req = 256; idle_on = 1'b0;
                end
                2: begin
                    configure($urandom, 21'd0);
                    alloc_pct = 50; max_req = 64; idle_on = 1'b1;
                end
                3: begin
                    configure($urandom, 21'd1);
                    alloc_pct = 40; max_req = 64; idle_on = 1'b1;
                end
                4: begin
                    configure($urandom, TOP_W'($urandom_range(64, 8192)));
                    alloc_pct = 55; max_req = 512; idle_on = 1'b1;
                end
                5: begin
                    configure(32'h0, 21'd1048576);
                    alloc_pct = 85; max_req = 64; idle_on = 1'b0;
                end
                default: begin
                    configure($urandom, TOP_W'($urandom_range(1, 21'h1F_FFFF)));
                    alloc_pct = $urandom_range(40, 80);
                    max_req   = $urandom_range(16, 8192);
                    idle_on   = ph[0];
                end
            endcase
            for (k = 0; k < 95; k++)
                random_word(alloc_pct, max_req);
        end

        drain_results();
        repeat (5) @(posedge aclk);
        if (book.errors == 0 && book.pending() == 0)
            $display("stack_allocator_engine_tb OK");
        else
            $display("stack_allocator_engine_tb NOT OK");
        $finish;
    end

endmodule
